@@ sv/tlb_probe_read_unit_core_macros.svh @@
// ----------------------------------------------------------------------------
// tlb probe/read unit assertion macros
// shared concurrent check forms, clocked on clk_i and idle during reset
// ----------------------------------------------------------------------------
`ifndef TLB_PROBE_READ_UNIT_CORE_MACROS_SVH
`define TLB_PROBE_READ_UNIT_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define TLBPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define TLBPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tlbpr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbpr_pkg
// types, constants and entry functions of the tlb probe/read unit
// ----------------------------------------------------------------------------
package tlbpr_pkg;

  // operation codes
  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActRead  = 2'd1,
    ActProbe = 2'd2
  } tlbpr_action_e;

  localparam int unsigned IdxW = 6;

  localparam logic [31:0] MissWord   = 32'h8000_0000;
  localparam logic [31:0] VpnMask    = 32'h0007_ffff;
  localparam logic [31:0] PmReadMask = 32'h01ff_e000;
  localparam logic [31:0] HiFixedClr = 32'h0000_1f00;
  localparam logic [31:0] Lo0Clr     = 32'hfc00_0001;
  localparam logic [31:0] Lo1Clr     = 32'h7c00_0001;

  // one stored tlb entry
  typedef struct packed {
    logic [31:0] page_mask;
    logic [31:0] hi;
    logic [31:0] lo0;
    logic [31:0] lo1;
  } tlbpr_entry_t;

  // request to the entry memory
  typedef struct packed {
    logic         we;
    logic         re;
    logic [IdxW-1:0] addr;
    tlbpr_entry_t wdata;
  } tlbpr_req_t;

  // probe match of one entry against an entry-hi key
  function automatic logic tlbpr_hit(tlbpr_entry_t e, logic [31:0] key);
    logic [31:0] keep;
    logic [31:0] stored;
    logic [31:0] probe;
    keep   = ~{20'b0, e.page_mask[24:13]};
    stored = ({13'b0, e.hi[31:13]} & VpnMask & keep) << 13;
    probe  = key & VpnMask & keep;
    return (stored == probe) &&
           ((e.lo0[0] & e.lo1[0]) || (e.hi[7:0] == key[31:24]));
  endfunction

  // entry in coprocessor register form
  function automatic tlbpr_entry_t tlbpr_fmt_read(tlbpr_entry_t e);
    tlbpr_entry_t r;
    logic         g;
    g           = e.lo0[0] & e.lo1[0];
    r.page_mask = e.page_mask & PmReadMask;
    r.hi        = e.hi & ~(HiFixedClr | r.page_mask);
    r.lo0       = (e.lo0 & ~Lo0Clr) | {31'b0, g};
    r.lo1       = (e.lo1 & ~Lo1Clr) | {31'b0, g};
    return r;
  endfunction

endpackage

@@ sv/tlbpr_store.sv @@
// ----------------------------------------------------------------------------
// tlbpr_store
// entry memory, one write and one read per cycle, registered read data;
// per-entry valid bits make never-written entries read as zero
// ----------------------------------------------------------------------------
module tlbpr_store #(
  parameter int unsigned ENTRY_COUNT = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlbpr_pkg::tlbpr_req_t   req_i,
  output tlbpr_pkg::tlbpr_entry_t rd_entry_o
);
  import tlbpr_pkg::*;

  localparam int unsigned AddrW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  tlbpr_entry_t           mem_q [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid_q;
  tlbpr_entry_t           rd_data_q;
  logic                   rd_valid_q;
  logic [AddrW-1:0]       addr;

  assign addr = req_i.addr[AddrW-1:0];

  // memory array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // valid bits, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[addr];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

@@ sv/tlb_probe_read_unit_core.sv @@
// ----------------------------------------------------------------------------
// tlb_probe_read_unit_core
// tlb entry table with write, read and probe operations
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken at a clock edge with start high and busy low.
//   every command gives exactly one result beat, shown for one cycle with
//   done_o high; the receiver cannot stall it and must take it then.
// sequence, from the accepting edge:
//   write, bad index, unused action: result beat registered at once, busy stays low
//   read: busy high in ReadSt while the memory read lands, then the result beat
//   probe: busy high in ProbeSt until the first hit or the last entry;
//     the single read port of the entry memory walks one entry per cycle
// a new command may be taken in the same cycle a result is shown.
// reset clears the per-entry valid bits, so every entry reads as zero at
// once; no clearing pass is needed. no write can overlap a read or probe
// walk, since commands are held off while busy is high.
// ----------------------------------------------------------------------------
`include "tlb_probe_read_unit_core_macros.svh"

module tlb_probe_read_unit_core #(
  parameter int unsigned ENTRY_COUNT = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] page_mask_in_i,
  input  logic [31:0] entry_hi_in_i,
  input  logic [31:0] entry_lo0_in_i,
  input  logic [31:0] entry_lo1_in_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [31:0] index_word_o,
  output logic [31:0] page_mask_out_o,
  output logic [31:0] entry_hi_out_o,
  output logic [31:0] entry_lo0_out_o,
  output logic [31:0] entry_lo1_out_o
);
  import tlbpr_pkg::*;

  localparam int unsigned AddrW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(ENTRY_COUNT - 1);

  typedef enum logic [1:0] {
    IdleSt,
    ReadSt,
    ProbeSt
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] cmp_idx_q;
  logic [31:0]      key_q;
  logic             done_q;
  logic             accepted_q;
  logic [31:0]      index_word_q;
  tlbpr_entry_t     rd_out_q;

  tlbpr_req_t   req;
  tlbpr_entry_t rd_entry;
  tlbpr_entry_t rd_fmt;
  logic         take;
  logic         in_range;
  logic         hit;
  logic         last;
  logic         res_zero;

  assign busy     = (state_q != IdleSt);
  assign take     = start && !busy;
  assign in_range = ({1'b0, entry_index_i} < 7'(ENTRY_COUNT));
  assign hit      = tlbpr_hit(rd_entry, key_q);
  assign last     = (cmp_idx_q == LastIdx);
  assign rd_fmt   = tlbpr_fmt_read(rd_entry);

  // memory request: writes and reads on accept, next entry during a probe walk
  always_comb begin
    req.we              = 1'b0;
    req.re              = 1'b0;
    req.addr            = entry_index_i;
    req.wdata.page_mask = page_mask_in_i;
    req.wdata.hi        = entry_hi_in_i;
    req.wdata.lo0       = entry_lo0_in_i;
    req.wdata.lo1       = entry_lo1_in_i;
    if (take) begin
      case (action_i)
        ActWrite: req.we = in_range;
        ActRead:  req.re = in_range;
        ActProbe: begin
          req.re   = 1'b1;
          req.addr = '0;
        end
        default: ;
      endcase
    end else if (state_q == ProbeSt) begin
      req.re   = !hit && !last;
      req.addr = IdxW'(cmp_idx_q) + IdxW'(1);
    end
  end

  tlbpr_store #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_entry_o(rd_entry)
  );

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IdleSt;
      cmp_idx_q    <= '0;
      key_q        <= '0;
      done_q       <= 1'b0;
      accepted_q   <= 1'b0;
      index_word_q <= '0;
      rd_out_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IdleSt: begin
          if (take) begin
            accepted_q   <= 1'b0;
            index_word_q <= '0;
            rd_out_q     <= '0;
            case (action_i)
              ActWrite: begin
                done_q     <= 1'b1;
                accepted_q <= in_range;
              end
              ActRead: begin
                if (in_range) begin
                  state_q <= ReadSt;
                end else begin
                  done_q <= 1'b1;
                end
              end
              ActProbe: begin
                state_q   <= ProbeSt;
                cmp_idx_q <= '0;
                key_q     <= entry_hi_in_i;
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        ReadSt: begin
          done_q     <= 1'b1;
          accepted_q <= 1'b1;
          rd_out_q   <= rd_fmt;
          state_q    <= IdleSt;
        end
        ProbeSt: begin
          if (hit || last) begin
            done_q       <= 1'b1;
            accepted_q   <= 1'b1;
            index_word_q <= hit ? 32'(cmp_idx_q) : MissWord;
            state_q      <= IdleSt;
          end else begin
            cmp_idx_q <= cmp_idx_q + AddrW'(1);
          end
        end
        default: state_q <= IdleSt;
      endcase
    end
  end

  assign done_o          = done_q;
  assign accepted_o      = accepted_q;
  assign index_word_o    = index_word_q;
  assign page_mask_out_o = rd_out_q.page_mask;
  assign entry_hi_out_o  = rd_out_q.hi;
  assign entry_lo0_out_o = rd_out_q.lo0;
  assign entry_lo1_out_o = rd_out_q.lo1;

  // checks
  assign res_zero = (index_word_o == '0) && (page_mask_out_o == '0) && (entry_hi_out_o == '0);

  `TLBPR_ASSERT(a_done_in_idle, !done_o || (state_q == IdleSt), "result beat outside idle")
  `TLBPR_ASSERT(a_write_idle, !req.we || (state_q == IdleSt), "write during a read or probe")
  `TLBPR_ASSERT_NEXT(a_read_result, state_q == ReadSt, done_o && accepted_o, "read gave no result")
  `TLBPR_ASSERT(a_reject_zero, !(done_o && !accepted_o) || res_zero, "rejected beat not zero")
  `TLBPR_ASSERT(a_miss_word, !(done_o && index_word_o[31]) || (index_word_o == MissWord), "bad probe miss word")

endmodule

@@ tb/tlb_table_model_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_table_model_pkg
// shadow copy of the tlb entry table that predicts every result beat of the
// probe/read unit and checks the observed beats in order
// ----------------------------------------------------------------------------
package tlb_table_model_pkg;

  import tlbpr_pkg::*;

  localparam int unsigned EntryCount = 48;
  localparam int unsigned ReportLimit = 10;

  // code with no operation behind it
  localparam logic [1:0] ActUnused = 2'd3;

  // one result beat
  typedef struct {
    logic        accepted;
    logic [31:0] index_word;
    logic [31:0] page_mask;
    logic [31:0] entry_hi;
    logic [31:0] entry_lo0;
    logic [31:0] entry_lo1;
  } tlb_result_t;

  class tlb_table_model;
    logic [31:0] mask_tbl[EntryCount];
    logic [31:0] hi_tbl[EntryCount];
    logic [31:0] lo0_tbl[EntryCount];
    logic [31:0] lo1_tbl[EntryCount];
    tlb_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      foreach (mask_tbl[i]) begin
        mask_tbl[i] = '0;
        hi_tbl[i]   = '0;
        lo0_tbl[i]  = '0;
        lo1_tbl[i]  = '0;
      end
      mismatches = 0;
    endfunction

    // first entry whose page number and asid (or global bit) fit the key
    function logic [31:0] search(logic [31:0] key);
      logic [31:0] keep;
      logic [31:0] entry_vpn;
      logic [31:0] key_vpn;
      logic        global_bit;
      for (int i = 0; i < EntryCount; i++) begin
        keep       = ~((mask_tbl[i] >> 13) & 32'h0000_0fff);
        entry_vpn  = ((hi_tbl[i] >> 13) & VpnMask & keep) << 13;
        key_vpn    = key & VpnMask & keep;
        global_bit = lo0_tbl[i][0] & lo1_tbl[i][0];
        if (entry_vpn == key_vpn && (global_bit || hi_tbl[i][7:0] == key[31:24]))
          return 32'(i);
      end
      return MissWord;
    endfunction

    // update the shadow table for an accepted command and queue its result
    function void note_command(logic [1:0] act, logic [5:0] idx, logic [31:0] pm,
                               logic [31:0] hi, logic [31:0] lo0, logic [31:0] lo1);
      tlb_result_t r;
      logic [31:0] m;
      logic        g;
      r = '{accepted: 1'b0, index_word: '0, page_mask: '0, entry_hi: '0,
            entry_lo0: '0, entry_lo1: '0};
      case (act)
        ActWrite: begin
          if (idx < EntryCount) begin
            mask_tbl[idx] = pm;
            hi_tbl[idx]   = hi;
            lo0_tbl[idx]  = lo0;
            lo1_tbl[idx]  = lo1;
            r.accepted    = 1'b1;
          end
        end
        ActRead: begin
          if (idx < EntryCount) begin
            m           = mask_tbl[idx] & PmReadMask;
            g           = lo0_tbl[idx][0] & lo1_tbl[idx][0];
            r.accepted  = 1'b1;
            r.page_mask = m;
            r.entry_hi  = hi_tbl[idx] & ~(HiFixedClr | m);
            r.entry_lo0 = (lo0_tbl[idx] & ~Lo0Clr) | {31'b0, g};
            r.entry_lo1 = (lo1_tbl[idx] & ~Lo1Clr) | {31'b0, g};
          end
        end
        ActProbe: begin
          r.accepted   = 1'b1;
          r.index_word = search(hi);
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    // compare one field and log the first few misses
    function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%s mismatch: expected %h, got %h", fname, want, got);
      end
    endfunction

    // check an observed result beat against the oldest prediction
    function void check_result(logic acc, logic [31:0] idx_word, logic [31:0] pm,
                               logic [31:0] hi, logic [31:0] lo0, logic [31:0] lo1);
      tlb_result_t w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result beat with none pending: accepted %b index %h", acc, idx_word);
        return;
      end
      w = expected_q.pop_front();
      cmp_field("accepted", {31'b0, w.accepted}, {31'b0, acc});
      cmp_field("index_word", w.index_word, idx_word);
      cmp_field("page_mask_out", w.page_mask, pm);
      cmp_field("entry_hi_out", w.entry_hi, hi);
      cmp_field("entry_lo0_out", w.entry_lo0, lo0);
      cmp_field("entry_lo1_out", w.entry_lo1, lo1);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // entry-hi key whose page number hits entry idx, given a well-formed entry
    function logic [31:0] probe_key_for(logic [5:0] idx, bit same_asid);
      logic [11:0] pmf;
      logic [18:0] vpn;
      logic [31:0] key;
      pmf = mask_tbl[idx][24:13];
      vpn = hi_tbl[idx][31:13];
      key = $urandom;
      if (same_asid)
        key[31:24] = hi_tbl[idx][7:0];
      key[18:13] = vpn[5:0] & ~pmf[5:0];
      key[12]    = 1'b0;
      key[11:0]  = key[11:0] & pmf;
      return key;
    endfunction
  endclass

endpackage

@@ tb/tb_tlb_probe_read_unit_core.sv @@
// ----------------------------------------------------------------------------
// tb_tlb_probe_read_unit_core
// drives write, read, probe and unused command beats into the tlb unit with
// random sender gaps and checks every result beat against a shadow table
// ----------------------------------------------------------------------------
module tb_tlb_probe_read_unit_core;

  timeunit 1ns;
  timeprecision 1ps;

  import tlbpr_pkg::*;
  import tlb_table_model_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBeats = 900;
  localparam int unsigned CalmTail    = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [5:0]  entry_index_i;
  logic [31:0] page_mask_in_i;
  logic [31:0] entry_hi_in_i;
  logic [31:0] entry_lo0_in_i;
  logic [31:0] entry_lo1_in_i;
  logic        done_o;
  logic        accepted_o;
  logic [31:0] index_word_o;
  logic [31:0] page_mask_out_o;
  logic [31:0] entry_hi_out_o;
  logic [31:0] entry_lo0_out_o;
  logic [31:0] entry_lo1_out_o;

  tlb_table_model table_model = new();

  // clock
  always #5ns clk_i = ~clk_i;

  tlb_probe_read_unit_core #(
    .ENTRY_COUNT(EntryCount)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .entry_index_i  (entry_index_i),
    .page_mask_in_i (page_mask_in_i),
    .entry_hi_in_i  (entry_hi_in_i),
    .entry_lo0_in_i (entry_lo0_in_i),
    .entry_lo1_in_i (entry_lo1_in_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .index_word_o   (index_word_o),
    .page_mask_out_o(page_mask_out_o),
    .entry_hi_out_o (entry_hi_out_o),
    .entry_lo0_out_o(entry_lo0_out_o),
    .entry_lo1_out_o(entry_lo1_out_o)
  );

  // result beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      table_model.check_result(accepted_o, index_word_o, page_mask_out_o,
                               entry_hi_out_o, entry_lo0_out_o, entry_lo1_out_o);
  end

  // run limit
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // present one command beat and hold it until taken; returns at a falling edge
  task automatic issue(input logic [1:0] act, input logic [5:0] idx, input logic [31:0] pm,
                       input logic [31:0] hi, input logic [31:0] lo0, input logic [31:0] lo1);
    start          <= 1'b1;
    action_i       <= act;
    entry_index_i  <= idx;
    page_mask_in_i <= pm;
    entry_hi_in_i  <= hi;
    entry_lo0_in_i <= lo0;
    entry_lo1_in_i <= lo1;
    do @(posedge clk_i); while (busy);
    table_model.note_command(act, idx, pm, hi, lo0, lo1);
    @(negedge clk_i);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // hold the sender off until every pending result beat has come
  task automatic drain();
    while (table_model.pending() != 0) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 3) == 0)
      pause($urandom_range(1, 3));
  endtask

  // one random command: mostly well-formed entries and hitting probes, some noise
  task automatic random_beat(input bit allow_gap);
    int unsigned kind;
    logic [1:0]  act;
    logic [5:0]  idx;
    logic [31:0] pm;
    logic [31:0] hi;
    logic [31:0] lo0;
    logic [31:0] lo1;
    kind = $urandom_range(0, 99);
    pm   = $urandom;
    hi   = $urandom;
    lo0  = $urandom;
    lo1  = $urandom;
    idx  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(48, 63))
                                       : 6'($urandom_range(0, 47));
    if (kind < 15) begin
      act = 2'($urandom_range(0, 3));
      idx = 6'($urandom_range(0, 63));
    end else if (kind < 50) begin
      act = ActWrite;
      // keep the upper page number bits inside the mask so probes can hit
      hi  = {7'b0, 6'($urandom) & pm[24:19], 19'($urandom)};
    end else if (kind < 70) begin
      act = ActRead;
    end else begin
      act = ActProbe;
      if (kind < 92)
        hi = table_model.probe_key_for(6'($urandom_range(0, 47)), 1'($urandom_range(0, 1)));
    end
    issue(act, idx, pm, hi, lo0, lo1);
    maybe_gap(allow_gap);
  endtask

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    action_i       = ActWrite;
    entry_index_i  = '0;
    page_mask_in_i = '0;
    entry_hi_in_i  = '0;
    entry_lo0_in_i = '0;
    entry_lo1_in_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // cleared table: zero key hits entry zero, all-ones key misses
    issue(ActProbe, 6'd0, '0, 32'h0000_0000, '0, '0);
    issue(ActProbe, 6'd0, '0, 32'hffff_ffff, '0, '0);
    issue(ActRead, 6'd0, '0, '0, '0, '0);
    maybe_gap(1'b1);

    // index extremes, in and out of range
    issue(ActWrite, 6'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(ActRead, 6'd0, '0, '0, '0, '0);
    issue(ActWrite, 6'd47, 32'h0000_0000, 32'h0000_605a, 32'h0000_0000, 32'h0000_0001);
    issue(ActRead, 6'd47, '0, '0, '0, '0);
    issue(ActWrite, 6'd48, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(ActWrite, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(ActRead, 6'd48, '0, '0, '0, '0);
    issue(ActRead, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // unused action code
    issue(ActUnused, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(ActUnused, 6'd0, '0, '0, '0, '0);
    pause(2);

    // asid hit on the last entry, then an asid miss
    issue(ActProbe, 6'd0, '0, table_model.probe_key_for(6'd47, 1'b1), '0, '0);
    issue(ActProbe, 6'd0, '0, table_model.probe_key_for(6'd47, 1'b0), '0, '0);

    // global entry with the widest mask, then a non-global twin in front of it
    issue(ActWrite, 6'd5, 32'h01ff_e000, 32'h01f5_5a5a, 32'hffff_ffff, 32'h0000_0001);
    issue(ActProbe, 6'd0, '0, table_model.probe_key_for(6'd5, 1'b0), '0, '0);
    issue(ActRead, 6'd5, '0, '0, '0, '0);
    issue(ActWrite, 6'd3, 32'h01ff_e000, 32'h01f5_5a12, 32'h0000_0000, 32'h0000_0000);
    issue(ActProbe, 6'd0, '0, table_model.probe_key_for(6'd3, 1'b1), '0, '0);
    issue(ActProbe, 6'd0, '0, table_model.probe_key_for(6'd5, 1'b0), '0, '0);
    issue(ActRead, 6'd3, '0, '0, '0, '0);
    drain();

    // random traffic, quiet sender at the end
    for (int unsigned n = 0; n < RandomBeats; n++) begin
      if (n == RandomBeats / 2)
        drain();
      random_beat(n < RandomBeats - CalmTail);
    end
    drain();
    repeat (EntryCount + 4) @(negedge clk_i);

    if (table_model.mismatches == 0 && table_model.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tlbpr_pkg.sv
sv/tlbpr_store.sv
sv/tlb_probe_read_unit_core.sv
tb/tlb_table_model_pkg.sv
tb/tb_tlb_probe_read_unit_core.sv
